/* src/bsc_pkg.sv */
`default_nettype none

package bsc_pkg;

    localparam int NUM_BLOCKS   = 128;
    localparam int PAYLOAD_BITS = 64;

    localparam int OP_W      = 2;
    localparam int BIDX_W    = 8;
    localparam int DATA_W    = 64;
    localparam int FREE_W    = 8;
    localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DEFRAG = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_MOVE = 4'b1000
    } state_t;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic [PAYLOAD_BITS-1:0] wdata;
        logic [IDX_W-1:0]        raddr;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic              status;
        logic              blk_used;
        logic [DATA_W-1:0] content;
        logic [FREE_W-1:0] free;
    } rsp_t;

endpackage

`default_nettype wire

/* src/bsc_ram.sv */
`default_nettype none

module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/bsc_ctrl.sv */
`default_nettype none

module bsc_ctrl
    import bsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [BIDX_W-1:0]       block_index,
    input  wire logic [DATA_W-1:0]       payload,
    input  wire logic                    out_free,
    input  wire logic [PAYLOAD_BITS-1:0] mem_rdata,
    output mem_req_t                     mem_req,
    output rsp_t                         rsp
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

    state_t                  state_reg, state_next;
    logic [NUM_BLOCKS-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]        free_reg, free_next;
    logic [IDX_W-1:0]        src_reg, src_next;
    logic [IDX_W-1:0]        dst_reg, dst_next;
    logic                    rd_used_reg, rd_used_next;

    logic                    accept;
    logic                    in_range;
    logic [IDX_W-1:0]        idx;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign in_range = {1'b0, block_index} < (BIDX_W + 1)'(NUM_BLOCKS);
    assign idx      = block_index[IDX_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        free_next    = free_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        rd_used_next = rd_used_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = idx;
        mem_req.wdata = payload[PAYLOAD_BITS-1:0];
        mem_req.raddr = (state_reg == S_IDLE) ? idx : src_reg;

        rsp.valid    = 1'b0;
        rsp.status   = ST_OK;
        rsp.blk_used = 1'b0;
        rsp.content  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_ADD:
                        begin
                            rsp.valid = 1'b1;
                            if (in_range && !used_reg[idx])
                            begin
                                mem_req.we     = 1'b1;
                                used_next[idx] = 1'b1;
                                if (free_reg != '0)
                                begin
                                    free_next = free_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                rsp.status = ST_ERR;
                            end
                        end
                        OP_DEFRAG:
                        begin
                            src_next   = '0;
                            dst_next   = '0;
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                rd_used_next = used_reg[idx];
                                state_next   = S_READ;
                            end
                            else
                            begin
                                rsp.valid  = 1'b1;
                                rsp.status = ST_ERR;
                            end
                        end
                        default:
                        begin
                            rsp.valid  = 1'b1;
                            rsp.status = ST_ERR;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp.valid    = 1'b1;
                rsp.blk_used = rd_used_reg;
                rsp.content  = rd_used_reg ? DATA_W'(mem_rdata) : '0;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                if (used_reg[src_reg] && (src_reg != dst_reg))
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    if (used_reg[src_reg])
                    begin
                        dst_next = dst_reg + IDX_W'(1);
                    end
                    if (src_reg == LAST)
                    begin
                        rsp.valid  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        src_next = src_reg + IDX_W'(1);
                    end
                end
            end
            S_MOVE:
            begin
                // a free block reads back as zero, so the vacated entry needs no write
                mem_req.we         = 1'b1;
                mem_req.waddr      = dst_reg;
                mem_req.wdata      = mem_rdata;
                used_next[dst_reg] = 1'b1;
                used_next[src_reg] = 1'b0;
                dst_next           = dst_reg + IDX_W'(1);
                if (src_reg == LAST)
                begin
                    rsp.valid  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    src_next   = src_reg + IDX_W'(1);
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp.free = FREE_W'(free_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            free_reg  <= CNT_W'(NUM_BLOCKS);
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_used_reg <= rd_used_next;
    end

endmodule

`default_nettype wire

/* src/block_store_compactor.sv */
// Channel  Handshake            Payload
// in       in_valid / in_ready  op, block_index, payload
// out      out_valid/out_ready  status, block_used, block_content, free_count
//
// Add and any error: result registered at the transfer edge.
// Read: one payload RAM read then the result register.
// Defragment: scans the blocks in order, moving used blocks down; a move costs
//   a RAM read then a write through the single read/write port pair.
// Reset clears the used flags and sets the free count to NUM_BLOCKS; a read of
//   a free block returns zero whatever the RAM holds, so the RAM needs no clearing.
// One item in flight; in_ready drops while busy or while a result waits
//   unclaimed.
`default_nettype none

module block_store_compactor
    import bsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [BIDX_W-1:0]   block_index,
    input  wire logic [DATA_W-1:0]   payload,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     status,
    output logic                     block_used,
    output logic [DATA_W-1:0]        block_content,
    output logic [FREE_W-1:0]        free_count
);

    mem_req_t                mem_req;
    rsp_t                    rsp;
    logic [PAYLOAD_BITS-1:0] mem_rdata;
    logic                    out_free;
    logic                    out_valid_reg, out_valid_next;
    logic                    status_reg;
    logic                    block_used_reg;
    logic [DATA_W-1:0]       block_content_reg;
    logic [FREE_W-1:0]       free_count_reg;

    assign out_free = !out_valid_reg || out_ready;

    bsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .block_index (block_index),
        .payload     (payload),
        .out_free    (out_free),
        .mem_rdata   (mem_rdata),
        .mem_req     (mem_req),
        .rsp         (rsp)
    );

    bsc_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        if (rsp.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            status_reg        <= rsp.status;
            block_used_reg    <= rsp.blk_used;
            block_content_reg <= rsp.content;
            free_count_reg    <= rsp.free;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_used    = block_used_reg;
    assign block_content = block_content_reg;
    assign free_count    = free_count_reg;

endmodule

`default_nettype wire

/* src/bsc_checker.sv */
`default_nettype none

module bsc_checker
    import bsc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [OP_W-1:0]   op,
    input wire logic [BIDX_W-1:0] block_index,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              status,
    input wire logic              block_used,
    input wire logic [DATA_W-1:0] block_content,
    input wire logic [FREE_W-1:0] free_count
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_content)
            && $stable(status) && $stable(free_count))
        else $error("result changed while stalled");

    a_add_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (op == OP_ADD)
            && ({1'b0, block_index} >= (BIDX_W + 1)'(NUM_BLOCKS))
        |=> out_valid && (status == ST_ERR))
        else $error("out of range add not rejected");

    a_defrag_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (op == OP_DEFRAG) |=> !in_ready)
        else $error("input taken during defragment");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ERR) |-> !block_used && (block_content == '0))
        else $error("error result carries block data");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !out_valid || out_ready)
        else $error("input taken while result stuck");

endmodule

bind block_store_compactor bsc_checker u_bsc_checker (.*);

`default_nettype wire
